// ===== sv/krs_pkg.sv =====
// Shared types, constants and helpers for the key rank sorter.
// No dependencies; every other file of the block but krs_rank_mem refers to it by scoped names.
package krs_pkg;

    localparam int CHAR_W = 8;
    localparam int IDX_W  = 6;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    // outcome of a byte-serial key compare, seen from the other key
    typedef enum logic [1:0] {
        CMP_EQ = 2'b00,
        CMP_LT = 2'b01,
        CMP_GT = 2'b10
    } t_cmp;

    function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== sv/krs_if.sv =====
// Handshake channels of the key rank sorter: key characters in, record indices out.
// Depends on krs_pkg for the payload widths.
interface krs_key_if;
    logic                       valid;
    logic                       ready;
    logic [krs_pkg::CHAR_W-1:0] key_char;
    logic                       key_end;
    logic                       set_end;

    modport source (output valid, key_char, key_end, set_end, input ready);
    modport sink   (input valid, key_char, key_end, set_end, output ready);
endinterface

interface krs_idx_if;
    logic                      valid;
    logic                      ready;
    logic [krs_pkg::IDX_W-1:0] record_index;
    logic                      last;

    modport source (output valid, record_index, last, input ready);
    modport sink   (input valid, record_index, last, output ready);
endinterface

// ===== sv/krs_key_mem.sv =====
// Key byte memory: one write port, two registered read ports.
// Depends on krs_pkg for the byte width.
module krs_key_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [krs_pkg::CHAR_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [krs_pkg::CHAR_W-1:0] o_rdata_a,
    output logic [krs_pkg::CHAR_W-1:0] o_rdata_b
);

    logic [krs_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [krs_pkg::CHAR_W-1:0] r_rdata_a;
    logic [krs_pkg::CHAR_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sv/krs_rank_mem.sv =====
// Rank memory: maps a sorted place to a record index; one write, one registered read.
// No package dependency.
module krs_rank_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [$clog2(DEPTH)-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [$clog2(DEPTH)-1:0] o_rdata
);

    logic [$clog2(DEPTH)-1:0] r_mem [DEPTH];
    logic [$clog2(DEPTH)-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/key_rank_sorter.sv =====
// Top level of the key rank sorter: load sequencer, compare pipeline, emit and clear.
// Depends on krs_pkg, krs_if, krs_key_mem and krs_rank_mem.
//
//  channel   dir   handshake          payload
//  i_key     in    valid/ready        key_char[7:0], key_end, set_end
//  o_idx     out   valid/ready        record_index[5:0], last
//  i_cfg     in    i_cfg_we only      i_cfg_wdata (descending)
//
// Characters load at one per cycle into the key memory while i_key.ready is high.
// The closing item holds i_key.ready low through a compare pass over all n*n key pairs,
// byte by byte (two key memory reads per cycle), a drain state, an emit state that issues
// a rank read only once the previous one is registered, plus any o_idx stall, then a pass
// that zeroes the used key rows (n = records in the set).
// After reset a pass zeroes the whole key memory first.
// The output register lets a held result coexist with loading of the next set.
module key_rank_sorter #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_CHARS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    krs_key_if.sink     i_key,
    krs_idx_if.source   o_idx,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int IDX_W  = krs_pkg::IDX_W;
    localparam int REC_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int POS_W  = $clog2(KEY_CHARS + 1);
    localparam int JW     = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int DEPTH  = MAX_RECORDS * KEY_CHARS;
    localparam int ADDR_W = $clog2(DEPTH);

    krs_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [REC_W-1:0]  r_a, n_a;
    logic [REC_W-1:0]  r_i, n_i;
    logic [JW-1:0]     r_j, n_j;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_clr_end, n_clr_end;
    logic [REC_W-1:0]  r_k, n_k;
    logic              r_desc;

    // compare pipeline tags, aligned with the key memory read data
    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last;
    logic              r_s1_before;
    logic              r_s1_a_first;
    logic              r_s1_a_done;
    logic [REC_W-1:0]  r_s1_a;
    krs_pkg::t_cmp     r_cmp;
    logic [REC_W-1:0]  r_rank;

    logic              r_rd_pend;
    logic              r_rd_last;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic                       in_xfer;
    logic [CNT_W-1:0]           cnt_m1;
    logic                       room;
    logic                       pos_room;
    logic                       j_last;
    logic                       i_last;
    logic                       a_last;
    logic                       k_last;
    logic                       emit_issue;
    logic [REC_W-1:0]           emit_slot;
    logic [ADDR_W-1:0]          load_addr;
    logic [ADDR_W-1:0]          raddr_a;
    logic [ADDR_W-1:0]          raddr_i;
    logic                       kmem_we;
    logic [ADDR_W-1:0]          kmem_waddr;
    logic [krs_pkg::CHAR_W-1:0] kmem_wdata;
    logic [krs_pkg::CHAR_W-1:0] byte_a;
    logic [krs_pkg::CHAR_W-1:0] byte_i;
    krs_pkg::t_cmp              cmp_cur;
    krs_pkg::t_cmp              cmp_res;
    logic                       rank_inc;
    logic [REC_W-1:0]           rank_base;
    logic [REC_W-1:0]           rank_new;
    logic                       rank_we;
    logic [REC_W-1:0]           rank_rdata;

    assign in_xfer  = i_key.valid && i_key.ready;
    assign cnt_m1   = r_count - CNT_W'(1);
    assign room     = r_count < CNT_W'(MAX_RECORDS);
    assign pos_room = r_pos < POS_W'(KEY_CHARS);
    assign j_last   = r_j == JW'(KEY_CHARS - 1);
    assign i_last   = r_i == cnt_m1[REC_W-1:0];
    assign a_last   = r_a == cnt_m1[REC_W-1:0];
    assign k_last   = r_k == cnt_m1[REC_W-1:0];

    assign load_addr = ADDR_W'(r_count[REC_W-1:0]) * ADDR_W'(KEY_CHARS) + ADDR_W'(r_pos);
    assign raddr_a   = ADDR_W'(r_a) * ADDR_W'(KEY_CHARS) + ADDR_W'(r_j);
    assign raddr_i   = ADDR_W'(r_i) * ADDR_W'(KEY_CHARS) + ADDR_W'(r_j);

    assign emit_issue = (r_state == krs_pkg::ST_EMIT) && !r_rd_pend
                        && (!r_out_valid || o_idx.ready);
    assign emit_slot  = r_desc ? (cnt_m1[REC_W-1:0] - r_k) : r_k;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_a        = r_a;
        n_i        = r_i;
        n_j        = r_j;
        n_clr_addr = r_clr_addr;
        n_clr_end  = r_clr_end;
        n_k        = r_k;
        kmem_we    = 1'b0;
        kmem_waddr = load_addr;
        kmem_wdata = krs_pkg::lower_byte(i_key.key_char);
        case (r_state)
            krs_pkg::ST_CLEAR: begin
                kmem_we    = 1'b1;
                kmem_waddr = r_clr_addr;
                kmem_wdata = '0;
                if (r_clr_addr == r_clr_end) begin
                    n_state = krs_pkg::ST_LOAD;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            krs_pkg::ST_LOAD: begin
                if (in_xfer) begin
                    // drop whole keys once the set is full, and bytes past the key length
                    if (room) begin
                        if (pos_room) begin
                            kmem_we = 1'b1;
                            n_pos   = r_pos + POS_W'(1);
                        end
                        if (i_key.key_end || i_key.set_end) begin
                            n_count = r_count + CNT_W'(1);
                            n_pos   = '0;
                        end
                    end
                    if (i_key.set_end) begin
                        n_state = krs_pkg::ST_CMP;
                        n_a     = '0;
                        n_i     = '0;
                        n_j     = '0;
                    end
                end
            end
            krs_pkg::ST_CMP: begin
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_i = '0;
                        if (a_last) begin
                            n_state = krs_pkg::ST_DRAIN;
                        end else begin
                            n_a = r_a + REC_W'(1);
                        end
                    end else begin
                        n_i = r_i + REC_W'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            krs_pkg::ST_DRAIN: begin
                n_state = krs_pkg::ST_EMIT;
                n_k     = '0;
            end
            krs_pkg::ST_EMIT: begin
                if (emit_issue) begin
                    if (k_last) begin
                        // zero only the rows this set used
                        n_state    = krs_pkg::ST_CLEAR;
                        n_clr_addr = '0;
                        n_clr_end  = ADDR_W'(r_count) * ADDR_W'(KEY_CHARS) - ADDR_W'(1);
                        n_count    = '0;
                        n_pos      = '0;
                    end else begin
                        n_k = r_k + REC_W'(1);
                    end
                end
            end
            default: begin
                n_state = krs_pkg::ST_CLEAR;
            end
        endcase
    end

    // byte compare of key i against key a, carried across the bytes of one pair
    always_comb begin
        cmp_cur = r_s1_first ? krs_pkg::CMP_EQ : r_cmp;
        cmp_res = cmp_cur;
        if (cmp_cur == krs_pkg::CMP_EQ) begin
            if (byte_i < byte_a) begin
                cmp_res = krs_pkg::CMP_LT;
            end else if (byte_i > byte_a) begin
                cmp_res = krs_pkg::CMP_GT;
            end
        end
        rank_inc  = r_s1_last && ((cmp_res == krs_pkg::CMP_LT)
                    || ((cmp_res == krs_pkg::CMP_EQ) && r_s1_before));
        rank_base = r_s1_a_first ? '0 : r_rank;
        rank_new  = rank_base + REC_W'(rank_inc);
        rank_we   = r_s1_valid && r_s1_a_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krs_pkg::ST_CLEAR;
            r_count     <= '0;
            r_pos       <= '0;
            r_a         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_clr_addr  <= '0;
            r_clr_end   <= ADDR_W'(DEPTH - 1);
            r_k         <= '0;
            r_desc      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pos      <= n_pos;
            r_a        <= n_a;
            r_i        <= n_i;
            r_j        <= n_j;
            r_clr_addr <= n_clr_addr;
            r_clr_end  <= n_clr_end;
            r_k        <= n_k;
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
            r_s1_valid <= r_state == krs_pkg::ST_CMP;
            r_rd_pend  <= emit_issue;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_idx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first   <= r_j == '0;
        r_s1_last    <= j_last;
        r_s1_before  <= r_i < r_a;
        r_s1_a_first <= (r_i == '0) && (r_j == '0);
        r_s1_a_done  <= i_last && j_last;
        r_s1_a       <= r_a;
        if (r_s1_valid) begin
            r_cmp  <= cmp_res;
            r_rank <= rank_new;
        end
        if (emit_issue) begin
            r_rd_last <= k_last;
        end
        if (r_rd_pend) begin
            r_out_idx  <= IDX_W'(rank_rdata);
            r_out_last <= r_rd_last;
        end
    end

    krs_key_mem #(
        .DEPTH(DEPTH)
    ) u_key_mem (
        .i_clk    (i_clk),
        .i_we     (kmem_we),
        .i_waddr  (kmem_waddr),
        .i_wdata  (kmem_wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_i),
        .o_rdata_a(byte_a),
        .o_rdata_b(byte_i)
    );

    krs_rank_mem #(
        .DEPTH(MAX_RECORDS)
    ) u_rank_mem (
        .i_clk  (i_clk),
        .i_we   (rank_we),
        .i_waddr(rank_new),
        .i_wdata(r_s1_a),
        .i_raddr(emit_slot),
        .o_rdata(rank_rdata)
    );

    assign i_key.ready        = r_state == krs_pkg::ST_LOAD;
    assign o_idx.valid        = r_out_valid;
    assign o_idx.record_index = r_out_idx;
    assign o_idx.last         = r_out_last;

endmodule

// ===== sv/krs_checker.sv =====
// Port-level checks for the key rank sorter, bound to every instance of the top level.
// Depends on krs_pkg for payload widths.
module krs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_set_end,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [krs_pkg::IDX_W-1:0] i_record_index,
    input logic                      i_last
);

    logic [1:0] r_sets_open, n_sets_open;
    logic       set_xfer;
    logic       last_xfer;

    assign set_xfer  = i_in_valid && i_in_ready && i_set_end;
    assign last_xfer = i_out_valid && i_out_ready && i_last;

    // count closed sets whose final result has not yet been transferred
    always_comb begin
        n_sets_open = r_sets_open;
        if (set_xfer && !last_xfer) begin
            n_sets_open = r_sets_open + 2'd1;
        end else if (last_xfer && !set_xfer && (r_sets_open != 2'd0)) begin
            n_sets_open = r_sets_open - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets_open <= 2'd0;
        end else begin
            r_sets_open <= n_sets_open;
        end
    end

    a_sort_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_xfer |=> !i_in_ready)
        else $error("input taken right after a closing transfer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("ports active right after reset");

    a_out_needs_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_sets_open != 2'd0))
        else $error("result offered with no closed set pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_record_index) && $stable(i_last)))
        else $error("stalled result changed");

endmodule

bind key_rank_sorter krs_checker u_krs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_key.valid),
    .i_in_ready    (i_key.ready),
    .i_set_end     (i_key.set_end),
    .i_out_valid   (o_idx.valid),
    .i_out_ready   (o_idx.ready),
    .i_record_index(o_idx.record_index),
    .i_last        (o_idx.last)
);
